/* rtl/snn_pkg.sv */
// ----------------------------------------------------------------------------
// snn_pkg: shared types and constants of the spiking network engine
// Item kinds, register indexes, controller states, datapath commands and
// the saturation helper used by the arithmetic.
// ----------------------------------------------------------------------------
`default_nettype none

package snn_pkg;

  localparam logic [2:0] KIND_ROW   = 3'd0;
  localparam logic [2:0] KIND_EDGE  = 3'd1;
  localparam logic [2:0] KIND_DRIVE = 3'd2;
  localparam logic [2:0] KIND_POT   = 3'd3;
  localparam logic [2:0] KIND_STEP  = 3'd4;
  localparam logic [2:0] KIND_READ  = 3'd5;

  localparam logic [2:0] CFG_REST   = 3'd0;
  localparam logic [2:0] CFG_THRESH = 3'd1;
  localparam logic [2:0] CFG_RESET  = 3'd2;
  localparam logic [2:0] CFG_MDECAY = 3'd3;
  localparam logic [2:0] CFG_SDECAY = 3'd4;
  localparam logic [2:0] CFG_GAIN   = 3'd5;
  localparam logic [2:0] CFG_DELAY  = 3'd6;
  localparam logic [2:0] CFG_REFR   = 3'd7;

  localparam logic signed [15:0] RST_REST   = 16'sd0;
  localparam logic signed [15:0] RST_THRESH = 16'sd256;
  localparam logic signed [15:0] RST_RESET  = 16'sd0;
  localparam logic [15:0]        RST_MDECAY = 16'd60000;
  localparam logic [15:0]        RST_SDECAY = 16'd60000;
  localparam logic [15:0]        RST_GAIN   = 16'd256;
  localparam logic [3:0]         RST_DELAY  = 4'd1;
  localparam logic [7:0]         RST_REFR   = 8'd2;

  localparam logic [8:0]  SPIKES_MAX = 9'd511;
  localparam logic [15:0] TALLY_MAX  = 16'hFFFF;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_MOD, ST_QCHK, ST_QRD, ST_RWAIT, ST_ROW, ST_ECHK,
    ST_ERD, ST_SWAIT, ST_SACC, ST_NRD, ST_N1, ST_N2, ST_N3, ST_N4, ST_N5,
    ST_FIN, ST_TRD, ST_TOUT
  } snn_state_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_CLEAR, OP_ACCEPT, OP_MOD_SUB, OP_SLOT_LATCH, OP_PRE_LATCH,
    OP_Q_NEXT, OP_EDGE_START, OP_EDGE_LATCH, OP_EDGE_NEXT, OP_SYN_READ,
    OP_SYN_ADD, OP_QUEUE_CLEAR, OP_REFR_DEC, OP_MUL1, OP_MUL2, OP_DRIVE,
    OP_MUL3, OP_FIRE, OP_STEP_DONE, OP_TALLY_READ, OP_TALLY_OUT
  } snn_op_t;

  typedef struct packed {
    snn_op_t op;
    logic    idle;
  } snn_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic cur_ge;
    logic q_ok;
    logic pre_ok;
    logic e_ok;
    logic t_ok;
    logic refr_nz;
    logic last_n;
  } snn_status_t;

  function automatic logic signed [15:0] sat16(input logic signed [31:0] x);
    logic signed [15:0] r;
    if (x > 32'sd32767) begin
      r = 16'sh7FFF;
    end else if (x < -32'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = x[15:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/snn_ctrl.sv */
// ----------------------------------------------------------------------------
// snn_ctrl: sequencer of the spiking network engine
// Walks the clearing pass, item acceptance, spike delivery and the neuron
// update, issuing one datapath command per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module snn_ctrl (
  input  wire                       clk,
  input  wire                       rst,
  input  wire                       in_fire,
  input  wire  [2:0]                in_kind,
  input  wire  snn_pkg::snn_status_t status,
  output snn_pkg::snn_cmd_t          cmd
);

  snn_pkg::snn_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= snn_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      snn_pkg::ST_CLEAR: if (status.clr_last) state_next = snn_pkg::ST_IDLE;
      snn_pkg::ST_IDLE: begin
        if (in_fire) begin
          if (in_kind == snn_pkg::KIND_STEP) begin
            state_next = snn_pkg::ST_MOD;
          end else if (in_kind == snn_pkg::KIND_READ) begin
            state_next = snn_pkg::ST_TRD;
          end
        end
      end
      snn_pkg::ST_MOD:   if (!status.cur_ge) state_next = snn_pkg::ST_QCHK;
      snn_pkg::ST_QCHK:  state_next = status.q_ok ? snn_pkg::ST_QRD : snn_pkg::ST_NRD;
      snn_pkg::ST_QRD:   state_next = status.pre_ok ? snn_pkg::ST_RWAIT : snn_pkg::ST_QCHK;
      snn_pkg::ST_RWAIT: state_next = snn_pkg::ST_ROW;
      snn_pkg::ST_ROW:   state_next = snn_pkg::ST_ECHK;
      snn_pkg::ST_ECHK:  state_next = status.e_ok ? snn_pkg::ST_ERD : snn_pkg::ST_QCHK;
      snn_pkg::ST_ERD:   state_next = status.t_ok ? snn_pkg::ST_SWAIT : snn_pkg::ST_ECHK;
      snn_pkg::ST_SWAIT: state_next = snn_pkg::ST_SACC;
      snn_pkg::ST_SACC:  state_next = snn_pkg::ST_ECHK;
      snn_pkg::ST_NRD:   state_next = snn_pkg::ST_N1;
      snn_pkg::ST_N1: begin
        if (status.refr_nz) begin
          state_next = status.last_n ? snn_pkg::ST_FIN : snn_pkg::ST_NRD;
        end else begin
          state_next = snn_pkg::ST_N2;
        end
      end
      snn_pkg::ST_N2:    state_next = snn_pkg::ST_N3;
      snn_pkg::ST_N3:    state_next = snn_pkg::ST_N4;
      snn_pkg::ST_N4:    state_next = snn_pkg::ST_N5;
      snn_pkg::ST_N5:    state_next = status.last_n ? snn_pkg::ST_FIN : snn_pkg::ST_NRD;
      snn_pkg::ST_FIN:   state_next = snn_pkg::ST_IDLE;
      snn_pkg::ST_TRD:   state_next = snn_pkg::ST_TOUT;
      snn_pkg::ST_TOUT:  state_next = snn_pkg::ST_IDLE;
      default:           state_next = snn_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd.idle = (state == snn_pkg::ST_IDLE);
    cmd.op   = snn_pkg::OP_NONE;
    case (state)
      snn_pkg::ST_CLEAR: cmd.op = snn_pkg::OP_CLEAR;
      snn_pkg::ST_IDLE:  cmd.op = in_fire ? snn_pkg::OP_ACCEPT : snn_pkg::OP_NONE;
      snn_pkg::ST_MOD:   cmd.op = status.cur_ge ? snn_pkg::OP_MOD_SUB : snn_pkg::OP_SLOT_LATCH;
      snn_pkg::ST_QCHK:  cmd.op = status.q_ok ? snn_pkg::OP_NONE : snn_pkg::OP_QUEUE_CLEAR;
      snn_pkg::ST_QRD:   cmd.op = status.pre_ok ? snn_pkg::OP_PRE_LATCH : snn_pkg::OP_Q_NEXT;
      snn_pkg::ST_ROW:   cmd.op = snn_pkg::OP_EDGE_START;
      snn_pkg::ST_ECHK:  cmd.op = status.e_ok ? snn_pkg::OP_NONE : snn_pkg::OP_Q_NEXT;
      snn_pkg::ST_ERD:   cmd.op = status.t_ok ? snn_pkg::OP_EDGE_LATCH : snn_pkg::OP_EDGE_NEXT;
      snn_pkg::ST_SWAIT: cmd.op = snn_pkg::OP_SYN_READ;
      snn_pkg::ST_SACC:  cmd.op = snn_pkg::OP_SYN_ADD;
      snn_pkg::ST_N1:    cmd.op = status.refr_nz ? snn_pkg::OP_REFR_DEC : snn_pkg::OP_MUL1;
      snn_pkg::ST_N2:    cmd.op = snn_pkg::OP_MUL2;
      snn_pkg::ST_N3:    cmd.op = snn_pkg::OP_DRIVE;
      snn_pkg::ST_N4:    cmd.op = snn_pkg::OP_MUL3;
      snn_pkg::ST_N5:    cmd.op = snn_pkg::OP_FIRE;
      snn_pkg::ST_FIN:   cmd.op = snn_pkg::OP_STEP_DONE;
      snn_pkg::ST_TRD:   cmd.op = snn_pkg::OP_TALLY_READ;
      snn_pkg::ST_TOUT:  cmd.op = snn_pkg::OP_TALLY_OUT;
      default:           cmd.op = snn_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

/* rtl/snn_datapath.sv */
// ----------------------------------------------------------------------------
// snn_datapath: storage and arithmetic of the spiking network engine
// Holds the configuration, the per-neuron memories, the graph, the delay
// ring and the output register, and carries out the sequencer's commands.
// ----------------------------------------------------------------------------
`default_nettype none

module snn_datapath #(
  parameter int NEURONS    = 256,
  parameter int EDGES      = 4096,
  parameter int RING_SLOTS = 16
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire  snn_pkg::snn_op_t op,
  output snn_pkg::snn_status_t status,
  input  wire  [2:0]           in_kind,
  input  wire  [12:0]          in_slot,
  input  wire  [7:0]           in_target,
  input  wire  signed [15:0]   in_data,
  input  wire  [12:0]          in_offset,
  input  wire                  cfg_we,
  input  wire  [2:0]           cfg_index,
  input  wire  [15:0]          cfg_data,
  input  wire                  out_ready,
  output logic                 out_valid,
  output logic [8:0]           out_spikes,
  output logic [15:0]          out_count
);

  localparam int NW = $clog2(NEURONS);
  localparam int RW = $clog2(NEURONS + 1);
  localparam int EW = (EDGES > 1) ? $clog2(EDGES) : 1;
  localparam int SW = (RING_SLOTS > 1) ? $clog2(RING_SLOTS) : 1;
  localparam int CW = $clog2(RING_SLOTS + 1);
  localparam int FW = $clog2(NEURONS + 1);
  localparam int QW = (RING_SLOTS * NEURONS > 1) ? $clog2(RING_SLOTS * NEURONS) : 1;

  // Configuration
  logic signed [15:0] cfg_rest, cfg_thresh, cfg_reset;
  logic [15:0]        cfg_mdecay, cfg_sdecay, cfg_gain;
  logic [3:0]         cfg_delay;
  logic [7:0]         cfg_refr;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_rest   <= snn_pkg::RST_REST;
      cfg_thresh <= snn_pkg::RST_THRESH;
      cfg_reset  <= snn_pkg::RST_RESET;
      cfg_mdecay <= snn_pkg::RST_MDECAY;
      cfg_sdecay <= snn_pkg::RST_SDECAY;
      cfg_gain   <= snn_pkg::RST_GAIN;
      cfg_delay  <= snn_pkg::RST_DELAY;
      cfg_refr   <= snn_pkg::RST_REFR;
    end else if (cfg_we) begin
      case (cfg_index)
        snn_pkg::CFG_REST:   cfg_rest   <= cfg_data;
        snn_pkg::CFG_THRESH: cfg_thresh <= cfg_data;
        snn_pkg::CFG_RESET:  cfg_reset  <= cfg_data;
        snn_pkg::CFG_MDECAY: cfg_mdecay <= cfg_data;
        snn_pkg::CFG_SDECAY: cfg_sdecay <= cfg_data;
        snn_pkg::CFG_GAIN:   cfg_gain   <= cfg_data;
        snn_pkg::CFG_DELAY:  cfg_delay  <= cfg_data[3:0];
        snn_pkg::CFG_REFR:   cfg_refr   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Working registers
  logic [12:0] idx_r;
  logic [CW-1:0] cursor, cur_w, slots_r;
  logic [SW-1:0] slot_r, fut_r;
  logic [FW-1:0] qn_r, q_r, fut_cnt;
  logic [NW-1:0] pre_r, i_r;
  logic [12:0] e_r, end_r;
  logic [7:0]  t_r;
  logic signed [15:0] w_r, g_r;
  logic [8:0]  spikes_r;
  logic [RW-1:0] clr_addr;
  logic signed [32:0] p_g, p_gg;
  logic signed [33:0] p_v;
  logic signed [25:0] d_r;
  logic signed [43:0] p_d;
  logic [FW-1:0] fill [RING_SLOTS];

  // Memory read data
  logic signed [15:0] mem_rd, syn_rd, drive_rd, ew_rd;
  logic [7:0]  refr_rd, et_rd;
  logic [15:0] tally_rd;
  logic [12:0] rs_a, rs_b;
  logic [NW-1:0] dq_rd;

  // Item checks and derived values
  logic in_n_ok, in_r_ok, in_e_ok, idx_n_ok;
  logic [CW-1:0] slots_calc;
  logic [CW:0]   fut_sum;
  logic [SW-1:0] fut_calc;
  logic [SW-1:0] fill_ra;
  logic [FW-1:0] fill_rd;
  logic [QW-1:0] dq_ra, dq_wa;
  logic [NW-1:0] n_raddr;
  logic signed [16:0] ag17, gain17, vdiff;
  logic [16:0] leak;
  logic signed [17:0] leak18;
  logic signed [15:0] g_calc, v_new, syn_sum;
  logic signed [31:0] v_sum;
  logic spike, out_set, step_kind;

  assign in_n_ok  = 32'(in_slot) < NEURONS;
  assign in_r_ok  = 32'(in_slot) < NEURONS + 1;
  assign in_e_ok  = 32'(in_slot) < EDGES;
  assign idx_n_ok = 32'(idx_r) < NEURONS;

  assign slots_calc = (32'(cfg_delay) + 32'd1 > RING_SLOTS) ? CW'(RING_SLOTS)
                                                             : CW'(32'(cfg_delay) + 32'd1);
  // The current slot is below the ring size, so one subtraction reduces the sum.
  assign fut_sum  = (CW + 1)'(cur_w) + (CW + 1)'(slots_r) - (CW + 1)'(1);
  assign fut_calc = (fut_sum >= (CW + 1)'(slots_r)) ? SW'(fut_sum - (CW + 1)'(slots_r))
                                                    : SW'(fut_sum);
  assign fill_ra = (op == snn_pkg::OP_SLOT_LATCH) ? SW'(cur_w) : fut_r;
  assign fill_rd = fill[fill_ra];
  assign dq_ra   = QW'(32'(slot_r) * NEURONS + 32'(q_r));
  assign dq_wa   = QW'(32'(fut_r) * NEURONS + 32'(fut_cnt));

  always_comb begin
    case (op)
      snn_pkg::OP_SYN_READ:   n_raddr = NW'(t_r);
      snn_pkg::OP_TALLY_READ: n_raddr = NW'(idx_r);
      default:                n_raddr = i_r;
    endcase
  end

  assign ag17    = signed'({1'b0, cfg_sdecay});
  assign gain17  = signed'({1'b0, cfg_gain});
  assign vdiff   = 17'(mem_rd) - 17'(cfg_rest);
  assign leak    = 17'h10000 - {1'b0, cfg_mdecay};
  assign leak18  = signed'({1'b0, leak});
  assign g_calc  = snn_pkg::sat16(32'(p_g >>> 16));
  assign v_sum   = 32'(cfg_rest) + 32'(p_v >>> 16) + 32'(p_d >>> 16);
  assign v_new   = snn_pkg::sat16(v_sum);
  assign spike   = (v_new >= cfg_thresh);
  assign syn_sum = snn_pkg::sat16(32'(syn_rd) + 32'(w_r));
  assign step_kind = (in_kind == snn_pkg::KIND_STEP) || (in_kind == snn_pkg::KIND_READ);
  assign out_set = ((op == snn_pkg::OP_ACCEPT) && !step_kind) ||
                   (op == snn_pkg::OP_STEP_DONE) || (op == snn_pkg::OP_TALLY_OUT);

  // Status to the sequencer
  assign status.clr_last = (clr_addr == RW'(NEURONS));
  assign status.cur_ge   = (cur_w >= slots_r);
  assign status.q_ok     = (q_r < qn_r);
  assign status.pre_ok   = (32'(dq_rd) < NEURONS);
  assign status.e_ok     = (e_r < end_r) && (32'(e_r) < EDGES);
  assign status.t_ok     = (32'(et_rd) < NEURONS);
  assign status.refr_nz  = (refr_rd != 8'd0);
  assign status.last_n   = (i_r == NW'(NEURONS - 1));

  // Working registers without reset
  always_ff @(posedge clk) begin
    case (op)
      snn_pkg::OP_ACCEPT: begin
        idx_r    <= in_slot;
        cur_w    <= cursor;
        slots_r  <= slots_calc;
        spikes_r <= '0;
      end
      snn_pkg::OP_MOD_SUB: cur_w <= cur_w - slots_r;
      snn_pkg::OP_SLOT_LATCH: begin
        slot_r <= SW'(cur_w);
        fut_r  <= fut_calc;
        qn_r   <= (32'(fill_rd) > NEURONS) ? FW'(NEURONS) : fill_rd;
        q_r    <= '0;
      end
      snn_pkg::OP_PRE_LATCH: pre_r <= dq_rd;
      snn_pkg::OP_Q_NEXT:    q_r <= q_r + FW'(1);
      snn_pkg::OP_EDGE_START: begin
        e_r   <= rs_a;
        end_r <= rs_b;
      end
      snn_pkg::OP_EDGE_LATCH: begin
        t_r <= et_rd;
        w_r <= ew_rd;
      end
      snn_pkg::OP_EDGE_NEXT: e_r <= e_r + 13'd1;
      snn_pkg::OP_SYN_ADD:   e_r <= e_r + 13'd1;
      snn_pkg::OP_QUEUE_CLEAR: i_r <= '0;
      snn_pkg::OP_REFR_DEC:    i_r <= i_r + NW'(1);
      snn_pkg::OP_MUL1: begin
        p_g <= syn_rd * ag17;
        p_v <= vdiff * 34'(signed'({1'b0, cfg_mdecay}));
      end
      snn_pkg::OP_MUL2: begin
        g_r  <= g_calc;
        p_gg <= g_calc * gain17;
      end
      snn_pkg::OP_DRIVE: d_r <= 26'(drive_rd) + 26'(p_gg >>> 8);
      snn_pkg::OP_MUL3:  p_d <= d_r * leak18;
      snn_pkg::OP_FIRE: begin
        i_r <= i_r + NW'(1);
        if (spike && spikes_r != snn_pkg::SPIKES_MAX) spikes_r <= spikes_r + 9'd1;
      end
      default: ;
    endcase
  end

  // Control state and the output register
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor    <= '0;
      fut_cnt   <= '0;
      clr_addr  <= '0;
      out_valid <= 1'b0;
      for (int s = 0; s < RING_SLOTS; s++) fill[s] <= '0;
    end else begin
      if (out_set) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (op)
        snn_pkg::OP_CLEAR: clr_addr <= clr_addr + RW'(1);
        snn_pkg::OP_QUEUE_CLEAR: begin
          fill[slot_r] <= '0;
          fut_cnt      <= (fut_r == slot_r) ? '0 : fill_rd;
        end
        snn_pkg::OP_FIRE: begin
          if (spike && 32'(fut_cnt) < NEURONS) fut_cnt <= fut_cnt + FW'(1);
        end
        snn_pkg::OP_STEP_DONE: begin
          fill[fut_r] <= fut_cnt;
          cursor <= ((CW'(slot_r) + CW'(1)) == slots_r) ? '0 : CW'(slot_r) + CW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (out_set) begin
      out_spikes <= (op == snn_pkg::OP_STEP_DONE) ? spikes_r : 9'd0;
      out_count  <= (op == snn_pkg::OP_TALLY_OUT && idx_n_ok) ? tally_rd : 16'd0;
    end
  end

  // Per-neuron memories, the graph memories and the delay queue
  logic signed [15:0] mem_v   [NEURONS];
  logic signed [15:0] syn_m   [NEURONS];
  logic signed [15:0] drive_m [NEURONS];
  logic [7:0]         refr_m  [NEURONS];
  logic [15:0]        tally_m [NEURONS];
  logic [12:0]        row_m   [NEURONS + 1];
  logic [7:0]         et_m    [EDGES];
  logic signed [15:0] ew_m    [EDGES];
  logic [NW-1:0]      dq_m    [RING_SLOTS * NEURONS];

  logic clr_n;
  logic v_we, s_we, d_we, r_we, t_we, row_we, e_we, q_we;
  logic [NW-1:0] v_wa, s_wa, d_wa, r_wa, t_wa, clr_na;
  logic [RW-1:0] row_wa;
  logic signed [15:0] v_wd, s_wd, d_wd;
  logic [7:0]  r_wd;
  logic [15:0] t_wd;
  logic [12:0] row_wd;

  assign clr_n  = (op == snn_pkg::OP_CLEAR) && (32'(clr_addr) < NEURONS);
  assign clr_na = NW'(clr_addr);

  always_comb begin
    v_we = 1'b0; v_wa = i_r; v_wd = v_new;
    s_we = 1'b0; s_wa = i_r; s_wd = g_r;
    d_we = 1'b0; d_wa = NW'(in_slot); d_wd = in_data;
    r_we = 1'b0; r_wa = i_r; r_wd = cfg_refr;
    t_we = 1'b0; t_wa = i_r; t_wd = tally_rd;
    row_we = 1'b0; row_wa = RW'(in_slot); row_wd = in_offset;
    e_we = (op == snn_pkg::OP_ACCEPT) && (in_kind == snn_pkg::KIND_EDGE) && in_e_ok;
    q_we = (op == snn_pkg::OP_FIRE) && spike && (32'(fut_cnt) < NEURONS);
    case (op)
      snn_pkg::OP_CLEAR: begin
        v_we = clr_n; v_wa = clr_na; v_wd = '0;
        s_we = clr_n; s_wa = clr_na; s_wd = '0;
        d_we = clr_n; d_wa = clr_na; d_wd = '0;
        r_we = clr_n; r_wa = clr_na; r_wd = '0;
        t_we = clr_n; t_wa = clr_na; t_wd = '0;
        row_we = 1'b1; row_wa = clr_addr; row_wd = '0;
      end
      snn_pkg::OP_ACCEPT: begin
        row_we = (in_kind == snn_pkg::KIND_ROW) && in_r_ok;
        d_we   = (in_kind == snn_pkg::KIND_DRIVE) && in_n_ok;
        v_we   = (in_kind == snn_pkg::KIND_POT) && in_n_ok;
        v_wa   = NW'(in_slot);
        v_wd   = in_data;
      end
      snn_pkg::OP_SYN_ADD: begin
        s_we = 1'b1; s_wa = NW'(t_r); s_wd = syn_sum;
      end
      snn_pkg::OP_REFR_DEC: begin
        r_we = 1'b1; r_wd = refr_rd - 8'd1;
      end
      snn_pkg::OP_FIRE: begin
        s_we = 1'b1;
        v_we = 1'b1;
        v_wd = spike ? cfg_reset : v_new;
        r_we = spike;
        t_we = spike;
        t_wd = (tally_rd == snn_pkg::TALLY_MAX) ? tally_rd : tally_rd + 16'd1;
      end
      snn_pkg::OP_TALLY_OUT: begin
        t_we = idx_n_ok; t_wa = NW'(idx_r); t_wd = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (v_we) mem_v[v_wa] <= v_wd;
    if (s_we) syn_m[s_wa] <= s_wd;
    if (d_we) drive_m[d_wa] <= d_wd;
    if (r_we) refr_m[r_wa] <= r_wd;
    if (t_we) tally_m[t_wa] <= t_wd;
    mem_rd   <= mem_v[n_raddr];
    syn_rd   <= syn_m[n_raddr];
    drive_rd <= drive_m[n_raddr];
    refr_rd  <= refr_m[n_raddr];
    tally_rd <= tally_m[n_raddr];
  end

  always_ff @(posedge clk) begin
    if (row_we) row_m[row_wa] <= row_wd;
    rs_a <= row_m[RW'(pre_r)];
    rs_b <= row_m[RW'(pre_r) + RW'(1)];
  end

  always_ff @(posedge clk) begin
    if (e_we) begin
      et_m[EW'(in_slot)] <= in_target;
      ew_m[EW'(in_slot)] <= in_data;
    end
    et_rd <= et_m[EW'(e_r)];
    ew_rd <= ew_m[EW'(e_r)];
  end

  always_ff @(posedge clk) begin
    if (q_we) dq_m[dq_wa] <= i_r;
    dq_rd <= dq_m[dq_ra];
  end

  // A result is only produced when the output register is free or draining.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    out_set && out_valid |-> out_ready)
    else $error("result produced over an untaken result");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    op == snn_pkg::OP_STEP_DONE |=> cursor < slots_r)
    else $error("ring cursor left outside the ring");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    op == snn_pkg::OP_FIRE |=> 32'(fut_cnt) <= NEURONS)
    else $error("delay slot overfilled");

endmodule

`default_nettype wire

/* rtl/spiking_neuron_network_step.sv */
// ----------------------------------------------------------------------------
// spiking_neuron_network_step: leaky integrate-and-fire network engine
// Items on the slave stream load the graph, drives and potentials, advance the
// network by one time step or read back a neuron's spike count. Each item
// gives exactly one result on the master stream.
// Load items and unknown kinds set their result as they are accepted; a count
// read passes through a tally read and a tally output step. A step handles the
// neurons one after another through one shared multiply chain, skipping the
// chain for a neuron still in its refractory count, and each delivered edge
// is a read-modify-write of the synaptic accumulator memory.
// After reset the block clears the per-neuron memories and the row pointers
// and accepts no item while it does so; configuration writes are
// taken throughout. A stalled receiver holds the result in the output
// register, and s_tready stays low until that result is transferred, so no
// further item is taken while it waits.
// ----------------------------------------------------------------------------
`default_nettype none

module spiking_neuron_network_step #(
  parameter int NEURONS    = 256,
  parameter int EDGES      = 4096,
  parameter int RING_SLOTS = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [55:0] s_tdata,  // slot_index, target_neuron, data_value, edge_offset
  input  wire  [2:0]  s_tuser,  // kind
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [31:0] m_tdata,  // spikes_this_step, neuron_spike_count
  input  wire         cfg_we,
  input  wire  [2:0]  cfg_index,
  input  wire  [15:0] cfg_data
);

  snn_pkg::snn_cmd_t    cmd;
  snn_pkg::snn_status_t status;
  logic       in_fire;
  logic [8:0]  out_spikes;
  logic [15:0] out_count;

  assign s_tready = cmd.idle && (!m_tvalid || m_tready);
  assign in_fire  = s_tvalid && s_tready;
  assign m_tdata  = {7'd0, out_count, out_spikes};

  snn_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_fire (in_fire),
    .in_kind (s_tuser),
    .status  (status),
    .cmd     (cmd)
  );

  snn_datapath #(
    .NEURONS    (NEURONS),
    .EDGES      (EDGES),
    .RING_SLOTS (RING_SLOTS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .op         (cmd.op),
    .status     (status),
    .in_kind    (s_tuser),
    .in_slot    (s_tdata[12:0]),
    .in_target  (s_tdata[20:13]),
    .in_data    (s_tdata[36:21]),
    .in_offset  (s_tdata[49:37]),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_ready  (m_tready),
    .out_valid  (m_tvalid),
    .out_spikes (out_spikes),
    .out_count  (out_count)
  );

endmodule

`default_nettype wire

/* tb/sv/spiking_neuron_network_step_tb.sv */
// ----------------------------------------------------------------------------
// spiking_neuron_network_step_tb: self-checking bench of the network engine
// Loads a small graph, then runs directed and random load, step and count read
// transfers under several register settings. A predictor computes each
// expected result and the monitor compares it field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module spiking_neuron_network_step_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NEURONS     = 256;
  localparam int EDGES       = 4096;
  localparam int RING_SLOTS  = 16;
  localparam int GRAPH_EDGES = 32;

  localparam logic [2:0] KIND_SPARE_A = 3'd6;
  localparam logic [2:0] KIND_SPARE_B = 3'd7;

  typedef struct {
    logic [2:0]         kind;
    logic [12:0]        idx;
    logic [7:0]         tgt;
    logic signed [15:0] val;
    logic [12:0]        off;
  } net_item_t;

  typedef struct {
    logic [8:0]  spikes;
    logic [15:0] count;
  } net_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;  // slot_index, target_neuron, data_value, edge_offset
  logic [2:0]  s_tuser = '0;  // kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;       // spikes_this_step, neuron_spike_count
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  spiking_neuron_network_step dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Mirrored register file.
  logic signed [15:0] rest_lvl = snn_pkg::RST_REST;
  logic signed [15:0] thresh_lvl = snn_pkg::RST_THRESH;
  logic signed [15:0] after_spike = snn_pkg::RST_RESET;
  logic [15:0]        mem_decay = snn_pkg::RST_MDECAY;
  logic [15:0]        syn_decay = snn_pkg::RST_SDECAY;
  logic [15:0]        syn_gain = snn_pkg::RST_GAIN;
  logic [3:0]         delay_cfg = snn_pkg::RST_DELAY;
  logic [7:0]         refr_cfg = snn_pkg::RST_REFR;

  // Mirrored network state.
  logic signed [15:0] membrane [NEURONS];
  logic signed [15:0] syn_acc [NEURONS];
  logic [7:0]         refr_left [NEURONS];
  logic signed [15:0] drive [NEURONS];
  logic [15:0]        tally [NEURONS];
  logic [12:0]        row_ptr [NEURONS+1];
  logic [7:0]         edge_dst [EDGES];
  logic signed [15:0] edge_w [EDGES];
  logic [7:0]         spike_queue [RING_SLOTS][NEURONS];
  int unsigned        slot_fill [RING_SLOTS];
  int unsigned        cursor = 0;

  net_item_t   pending_items[$];
  net_result_t expected_results[$];
  int          mismatches = 0;
  logic        no_idle = 1'b0;

  initial begin
    foreach (membrane[i]) begin
      membrane[i] = 0; syn_acc[i] = 0; refr_left[i] = 0; drive[i] = 0; tally[i] = 0;
    end
    foreach (row_ptr[i]) row_ptr[i] = 0;
    foreach (slot_fill[i]) slot_fill[i] = 0;
  end

  function automatic logic signed [15:0] clamp16(longint x);
    if (x > 32767) return 16'sh7FFF;
    if (x < -32768) return -16'sd32768;
    return x[15:0];
  endfunction

  function automatic logic [8:0] advance_network();
    longint      rest_v, g, d, v, md, sd, gn;
    int unsigned slots, slot, future, pre, e, t;
    logic [8:0]  fired;
    fired = 0;
    rest_v = rest_lvl;
    md = longint'(mem_decay);
    sd = longint'(syn_decay);
    gn = longint'(syn_gain);
    slots = delay_cfg + 1;
    if (slots > RING_SLOTS) slots = RING_SLOTS;
    slot = cursor % slots;
    future = (slot + slots - 1) % slots;
    for (int q = 0; q < slot_fill[slot] && q < NEURONS; q++) begin
      pre = spike_queue[slot][q];
      for (e = row_ptr[pre]; e < row_ptr[pre+1] && e < EDGES; e++) begin
        t = edge_dst[e];
        syn_acc[t] = clamp16(longint'(syn_acc[t]) + longint'(edge_w[e]));
      end
    end
    slot_fill[slot] = 0;
    for (int i = 0; i < NEURONS; i++) begin
      if (refr_left[i] > 0) begin
        refr_left[i]--;
        continue;
      end
      g = clamp16((longint'(syn_acc[i]) * sd) >>> 16);
      syn_acc[i] = g;
      d = longint'(drive[i]) + ((g * gn) >>> 8);
      v = rest_v + (((longint'(membrane[i]) - rest_v) * md) >>> 16)
        + ((d * (65536 - md)) >>> 16);
      v = clamp16(v);
      if (v >= longint'(thresh_lvl)) begin
        v = after_spike;
        refr_left[i] = refr_cfg;
        if (tally[i] != snn_pkg::TALLY_MAX) tally[i]++;
        if (slot_fill[future] < NEURONS) begin
          spike_queue[future][slot_fill[future]] = i;
          slot_fill[future]++;
        end
        if (fired != snn_pkg::SPIKES_MAX) fired++;
      end
      membrane[i] = v;
    end
    cursor = (slot + 1) % slots;
    return fired;
  endfunction

  function automatic net_result_t apply_item(net_item_t it);
    net_result_t r;
    r.spikes = 0;
    r.count = 0;
    case (it.kind)
      snn_pkg::KIND_ROW:   if (it.idx < NEURONS + 1) row_ptr[it.idx] = it.off;
      snn_pkg::KIND_EDGE:  if (it.idx < EDGES) begin
        edge_dst[it.idx] = it.tgt;
        edge_w[it.idx] = it.val;
      end
      snn_pkg::KIND_DRIVE: if (it.idx < NEURONS) drive[it.idx] = it.val;
      snn_pkg::KIND_POT:   if (it.idx < NEURONS) membrane[it.idx] = it.val;
      snn_pkg::KIND_STEP:  r.spikes = advance_network();
      snn_pkg::KIND_READ:  if (it.idx < NEURONS) begin
        r.count = tally[it.idx];
        tally[it.idx] = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Sender: one item per transfer, with a random gap after each one unless no_idle is set.
  int unsigned send_gap = 0;
  always @(posedge clk) begin
    net_item_t it;
    logic      taken;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      taken = s_tvalid && s_tready;
      if (taken) begin
        it.idx = s_tdata[12:0];
        it.tgt = s_tdata[20:13];
        it.val = s_tdata[36:21];
        it.off = s_tdata[49:37];
        it.kind = s_tuser;
        expected_results.push_back(apply_item(it));
      end
      if (!s_tvalid || taken) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          s_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          it = pending_items.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= {6'b0, it.off, it.val, it.tgt, it.idx};
          s_tuser <= it.kind;
          send_gap <= no_idle ? 0 : $urandom_range(0, 5);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stall after each result transfer unless no_idle is set.
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    net_result_t want;
    int unsigned n;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (m_tvalid && m_tready) begin
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", m_tdata);
      end else begin
        want = expected_results.pop_front();
        if (m_tdata[8:0] !== want.spikes || m_tdata[24:9] !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: spikes exp %0d got %0d, count exp %0d got %0d",
                     want.spikes, m_tdata[8:0], want.count, m_tdata[24:9]);
        end
      end
      n = no_idle ? 0 : $urandom_range(0, 5);
      stall_left <= n;
      m_tready <= (n == 0);
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_tready <= (stall_left == 1);
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic add_item(logic [2:0] kind, logic [12:0] idx, logic [7:0] tgt,
                          logic signed [15:0] val, logic [12:0] off);
    net_item_t it;
    it.kind = kind; it.idx = idx; it.tgt = tgt; it.val = val; it.off = off;
    pending_items.push_back(it);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      snn_pkg::CFG_REST:   rest_lvl = data;
      snn_pkg::CFG_THRESH: thresh_lvl = data;
      snn_pkg::CFG_RESET:  after_spike = data;
      snn_pkg::CFG_MDECAY: mem_decay = data;
      snn_pkg::CFG_SDECAY: syn_decay = data;
      snn_pkg::CFG_GAIN:   syn_gain = data;
      snn_pkg::CFG_DELAY:  delay_cfg = data[3:0];
      snn_pkg::CFG_REFR:   refr_cfg = data[7:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_registers(logic [15:0] rest_v, logic [15:0] thr_v, logic [15:0] rst_v,
                               logic [15:0] md, logic [15:0] sd, logic [15:0] gn,
                               logic [15:0] dl, logic [15:0] rf);
    write_reg(snn_pkg::CFG_REST, rest_v);
    write_reg(snn_pkg::CFG_THRESH, thr_v);
    write_reg(snn_pkg::CFG_RESET, rst_v);
    write_reg(snn_pkg::CFG_MDECAY, md);
    write_reg(snn_pkg::CFG_SDECAY, sd);
    write_reg(snn_pkg::CFG_GAIN, gn);
    write_reg(snn_pkg::CFG_DELAY, dl);
    write_reg(snn_pkg::CFG_REFR, rf);
  endtask

  // Every item gives a result, so a short pause after the last one suffices.
  task automatic drain();
    while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  // Mostly steps and neuron loads; row pointers stay inside the written edges.
  task automatic add_random_items(int n);
    int unsigned pick;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40)      add_item(snn_pkg::KIND_STEP, $urandom_range(0, 4096), 0, 0, 0);
      else if (pick < 55) add_item(snn_pkg::KIND_DRIVE, $urandom_range(0, 255), 0, $urandom, 0);
      else if (pick < 65) add_item(snn_pkg::KIND_POT, $urandom_range(0, 255), 0, $urandom, 0);
      else if (pick < 77) add_item(snn_pkg::KIND_READ, $urandom_range(0, 255), 0, 0, 0);
      else if (pick < 85)
        add_item(snn_pkg::KIND_ROW, $urandom_range(0, 256), 0, 0,
                 $urandom_range(0, GRAPH_EDGES));
      else if (pick < 93)
        add_item(snn_pkg::KIND_EDGE, $urandom_range(0, GRAPH_EDGES - 1), $urandom, $urandom, 0);
      else if (pick < 96)
        add_item($urandom_range(0, 1) ? KIND_SPARE_A : KIND_SPARE_B,
                 $urandom, $urandom, $urandom, $urandom);
      else
        add_item($urandom_range(0, 1) ? snn_pkg::KIND_READ : snn_pkg::KIND_DRIVE,
                 $urandom_range(256, 4096), 0, $urandom, 0);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // A small graph: neuron n of 0..7 owns the edges 4n to 4n+3.
    for (int e = 0; e < GRAPH_EDGES; e++)
      add_item(snn_pkg::KIND_EDGE, e, $urandom, $urandom_range(0, 1600) - 400, 0);
    for (int n = 0; n <= 8; n++) add_item(snn_pkg::KIND_ROW, n, 0, 0, 4 * n);
    for (int n = 0; n < 8; n++) add_item(snn_pkg::KIND_DRIVE, n, 0, 16'sd3000, 0);

    // Directed corners.
    add_item(snn_pkg::KIND_POT, 0, 0, 16'sh7FFF, 0);
    add_item(snn_pkg::KIND_POT, 255, 0, -16'sd32768, 0);
    add_item(snn_pkg::KIND_DRIVE, 255, 0, -16'sd32768, 0);
    add_item(snn_pkg::KIND_DRIVE, 254, 0, 16'sh7FFF, 0);
    add_item(snn_pkg::KIND_ROW, 300, 0, 0, 13'd4096);
    add_item(snn_pkg::KIND_ROW, 4096, 0, 0, 13'd4095);
    add_item(snn_pkg::KIND_EDGE, 4096, 8'hFF, 16'sh7FFF, 0);
    add_item(snn_pkg::KIND_EDGE, 4095, 8'hFF, -16'sd32768, 0);
    add_item(snn_pkg::KIND_POT, 4096, 0, 16'sh1234, 0);
    add_item(KIND_SPARE_A, 13'h1FFF, 8'hFF, -1, 13'h1FFF);
    add_item(KIND_SPARE_B, 0, 0, 0, 0);
    for (int s = 0; s < 5; s++) add_item(snn_pkg::KIND_STEP, 0, 0, 0, 0);
    add_item(snn_pkg::KIND_READ, 0, 0, 0, 0);
    add_item(snn_pkg::KIND_READ, 0, 0, 0, 0);
    add_item(snn_pkg::KIND_READ, 254, 0, 0, 0);
    add_item(snn_pkg::KIND_READ, 4096, 0, 0, 0);
    add_random_items(15);
    drain();

    // Lowest settings: everything fires each step.
    no_idle <= 1'b1;
    set_registers(16'h8000, 16'h8000, 16'h8000, 0, 0, 0, 0, 0);
    add_random_items(10);
    drain();

    // Highest settings.
    no_idle <= 1'b0;
    set_registers(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15, 255);
    add_random_items(10);
    drain();

    // Random settings with a low threshold so that spikes keep coming.
    for (int p = 0; p < 2; p++) begin
      no_idle <= $urandom_range(0, 1);
      set_registers($urandom_range(0, 512) - 512, $urandom_range(0, 600), $urandom,
                    $urandom, $urandom, $urandom_range(0, 2048),
                    $urandom_range(0, 15), $urandom_range(0, 4));
      add_random_items(8);
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire
